>>> rtl/ots_pkg.sv
// Package for the operator token scanner: item and token types, token class codes,
// character constants and classification functions.
// No dependencies.
package ots_pkg;

    localparam logic [2:0] CLS_ARITH   = 3'd0;
    localparam logic [2:0] CLS_ASSIGN  = 3'd1;
    localparam logic [2:0] CLS_EXP     = 3'd2;
    localparam logic [2:0] CLS_REL     = 3'd3;
    localparam logic [2:0] CLS_LOGIC   = 3'd4;
    localparam logic [2:0] CLS_UNKNOWN = 3'd5;
    localparam logic [2:0] CLS_OTHER   = 3'd6;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_text;
    } ots_in_t;

    typedef struct packed {
        logic [2:0] token_class;
        logic [7:0] first_char;
        logic [7:0] second_char;
        logic [1:0] lexeme_length;
        logic       run_last;
    } ots_out_t;

    typedef struct packed {
        logic [1:0] count;
        ots_out_t   tok0;
        ots_out_t   tok1;
    } ots_push_t;

    typedef struct packed {
        logic pending_valid;
    } ots_front_stat_t;

    function automatic logic is_starter(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
               c == CH_PERCENT || c == CH_LT || c == CH_GT || c == CH_EQ ||
               c == CH_BANG || c == CH_AMP || c == CH_PIPE;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE;
    endfunction

    function automatic logic [2:0] single_class(input logic [7:0] c);
        logic [2:0] cls;
        case (c)
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PERCENT: cls = CLS_ARITH;
            CH_LT, CH_GT:                                     cls = CLS_REL;
            CH_EQ:                                            cls = CLS_ASSIGN;
            CH_BANG:                                          cls = CLS_LOGIC;
            CH_AMP, CH_PIPE:                                  cls = CLS_UNKNOWN;
            default:                                          cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

    // Returns {hit, class} for the two-character form a followed by b.
    function automatic logic [3:0] pair_class(input logic [7:0] a, input logic [7:0] b);
        logic [3:0] res;
        res = {1'b0, CLS_OTHER};
        if (b == CH_EQ) begin
            case (a)
                CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PERCENT: res = {1'b1, CLS_ASSIGN};
                CH_LT, CH_GT, CH_EQ, CH_BANG:                     res = {1'b1, CLS_REL};
                default:                                          res = {1'b0, CLS_OTHER};
            endcase
        end else if (a == b) begin
            case (a)
                CH_PLUS, CH_MINUS: res = {1'b1, CLS_ARITH};
                CH_STAR:           res = {1'b1, CLS_EXP};
                CH_AMP, CH_PIPE:   res = {1'b1, CLS_LOGIC};
                default:           res = {1'b0, CLS_OTHER};
            endcase
        end
        return res;
    endfunction

endpackage

>>> rtl/operator_token_scanner_top.sv
// Operator token scanner top level: one character per cycle in, one token per cycle out
// unless stalled. A completed token passes through the token queue and the output register.
// Throughput is one character per cycle while the queue has room; a character that yields
// two tokens pushes both into the token queue (DEPTH entries, two free to accept).
// Asynchronous reset clears the pending character, the queue pointers and level, and the output valid flag.
// Depends on ots_pkg, ots_front, ots_queue and ots_back.
module operator_token_scanner_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_stall,
    input  ots_pkg::ots_in_t  char_item,
    output logic              token_valid,
    input  logic              token_stall,
    output ots_pkg::ots_out_t token_item
);
    import ots_pkg::*;

    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    ots_push_t       push;
    ots_front_stat_t front_stat;
    logic            room;
    logic            head_valid;
    ots_out_t        head;
    logic            pop;
    logic [LW-1:0]   level;

    ots_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .room       (room),
        .push       (push),
        .stat       (front_stat)
    );

    ots_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .level      (level)
    );

    ots_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item)
    );

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LW'(QUEUE_DEPTH))
        else $error("token queue level exceeds its depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> level <= LW'(QUEUE_DEPTH - 2))
        else $error("two tokens pushed without room");

    a_final_flush: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_stall && char_item.end_of_text |=> !front_stat.pending_valid)
        else $error("character left pending after the final item");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> level != '0)
        else $error("token popped from an empty queue");
`endif

endmodule

>>> rtl/ots_front.sv
// Front end of the operator token scanner: accepts characters, holds the pending
// character and forms up to two tokens per character. Depends on ots_pkg.
module ots_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     char_valid,
    output logic                     char_stall,
    input  ots_pkg::ots_in_t         char_item,
    input  logic                     room,
    output ots_pkg::ots_push_t       push,
    output ots_pkg::ots_front_stat_t stat
);
    import ots_pkg::*;

    logic       pend_valid_reg;
    logic       pend_valid_next;
    logic [7:0] pend_char_reg;
    logic [7:0] pend_char_next;

    logic       accept;
    logic [7:0] c;
    logic       last;
    logic [3:0] pc;
    logic       pair_hit;
    logic       have_p;
    logic       c_start;
    logic       c_emit;
    logic [1:0] n;
    ots_out_t   pair_tok;
    ots_out_t   p_tok;
    ots_out_t   c_tok;

    assign c          = char_item.char_byte;
    assign last       = char_item.end_of_text;
    assign char_stall = !room;
    assign accept     = char_valid && room;

    always_comb
    begin
        pc       = pair_class(pend_char_reg, c);
        pair_hit = pend_valid_reg && pc[3];
        have_p   = pend_valid_reg && !pc[3];
        c_start  = is_starter(c);
        c_emit   = !pair_hit && ((c_start && last) || (!c_start && !is_blank(c)));
        if (pair_hit) begin
            n = 2'd1;
        end else begin
            n = {1'b0, have_p} + {1'b0, c_emit};
        end

        pair_tok = '{token_class: pc[2:0], first_char: pend_char_reg, second_char: c,
                     lexeme_length: 2'd2, run_last: 1'b1};
        p_tok    = '{token_class: single_class(pend_char_reg), first_char: pend_char_reg,
                     second_char: 8'd0, lexeme_length: 2'd1, run_last: 1'b0};
        c_tok    = '{token_class: single_class(c), first_char: c, second_char: 8'd0,
                     lexeme_length: 2'd1, run_last: 1'b1};

        push.count = accept ? n : 2'd0;
        if (pair_hit) begin
            push.tok0 = pair_tok;
        end else if (have_p) begin
            push.tok0 = p_tok;
            push.tok0.run_last = !c_emit;
        end else begin
            push.tok0 = c_tok;
        end
        push.tok1 = c_tok;

        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        if (accept) begin
            pend_valid_next = !pair_hit && c_start && !last;
            pend_char_next  = pend_valid_next ? c : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_valid_reg <= 1'b0;
            pend_char_reg  <= 8'd0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            pend_char_reg  <= pend_char_next;
        end
    end

    assign stat.pending_valid = pend_valid_reg;

endmodule

>>> rtl/ots_queue.sv
// Token queue between the front and back ends of the operator token scanner:
// takes up to two tokens and gives one per cycle while the back end pops. Depends on ots_pkg.
module ots_queue #(
    parameter int DEPTH = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ots_pkg::ots_push_t        push,
    output logic                      room,
    output logic                      head_valid,
    output ots_pkg::ots_out_t         head,
    input  logic                      pop,
    output logic [$clog2(DEPTH+1)-1:0] level
);
    import ots_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    ots_out_t      entry [DEPTH];
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] wptr_next;
    logic [PW-1:0] wptr_1;
    logic [PW-1:0] rptr_reg;
    logic [PW-1:0] rptr_next;
    logic [LW-1:0] level_reg;
    logic [LW-1:0] level_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wptr_1 = ptr_inc(wptr_reg);
        case (push.count)
            2'd1:    wptr_next = wptr_1;
            2'd2:    wptr_next = ptr_inc(wptr_1);
            default: wptr_next = wptr_reg;
        endcase
        rptr_next  = pop ? ptr_inc(rptr_reg) : rptr_reg;
        level_next = level_reg + LW'(push.count) - LW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0) begin
            entry[wptr_reg] <= push.tok0;
        end
        if (push.count == 2'd2) begin
            entry[wptr_1] <= push.tok1;
        end
    end

    assign room       = level_reg <= LW'(DEPTH - 2);
    assign head_valid = level_reg != '0;
    assign head       = entry[rptr_reg];
    assign level      = level_reg;

endmodule

>>> rtl/ots_back.sv
// Back end of the operator token scanner: output register that takes tokens
// from the queue and presents them on the token channel. Depends on ots_pkg.
module ots_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  ots_pkg::ots_out_t head,
    output logic              pop,
    output logic              token_valid,
    input  logic              token_stall,
    output ots_pkg::ots_out_t token_item
);
    import ots_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    ots_out_t data_reg;

    assign pop        = head_valid && (!valid_reg || !token_stall);
    assign valid_next = pop ? 1'b1 : (valid_reg && token_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            data_reg <= head;
        end
    end

    assign token_valid = valid_reg;
    assign token_item  = data_reg;

endmodule
